// ===== design/spq_pkg.sv =====
package spq_pkg;

  typedef enum logic [1:0] {
    OP_PEEK   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 8;
  localparam int COUNT_W = 5;

  typedef struct packed {
    logic [1:0]                opcode;
    logic signed [VALUE_W-1:0] item_value;
    logic [PRIO_W-1:0]         priority_req;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] head_value;
    logic [PRIO_W-1:0]         head_priority;
    logic [COUNT_W-1:0]        entry_count;
    logic                      is_empty;
    logic [1:0]                status;
  } rsp_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                      insert;
    logic                      pop;
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         prio;
  } cell_cmd_t;

endpackage

// ===== design/spq_chan_if.sv =====
interface spq_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/spq_cell.sv =====
module spq_cell
  import spq_pkg::*;
(
  input  logic                      clk,
  input  cell_cmd_t                 cmd,
  input  logic                      occupied,
  input  logic                      left_ge,
  input  logic signed [VALUE_W-1:0] left_value,
  input  logic [PRIO_W-1:0]         left_prio,
  input  logic signed [VALUE_W-1:0] right_value,
  input  logic [PRIO_W-1:0]         right_prio,
  output logic                      ge,
  output logic signed [VALUE_W-1:0] value,
  output logic [PRIO_W-1:0]         prio,
  output logic signed [VALUE_W-1:0] value_next,
  output logic [PRIO_W-1:0]         prio_next
);

  // held entry stays ahead of the new one
  assign ge = occupied && (prio >= cmd.prio);

  always_comb begin
    value_next = value;
    prio_next  = prio;
    if (cmd.insert) begin
      if (!ge) begin
        if (left_ge) begin
          value_next = cmd.value;
          prio_next  = cmd.prio;
        end else begin
          value_next = left_value;
          prio_next  = left_prio;
        end
      end
    end else if (cmd.pop) begin
      value_next = right_value;
      prio_next  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    prio  <= prio_next;
  end

endmodule

// ===== design/sorted_priority_queue_top.sv =====
// channel  dir  payload                                                 beat when
// req      in   opcode, item_value, priority_req                        valid && ready
// rsp      out  head_value, head_priority, entry_count, is_empty, status valid && ready
//
// one operation per cycle unless rsp stalls: the chain of DEPTH cells shifts in
// the same cycle the request beat is taken, and the response is registered
// the response register sets the rate; req is ready whenever it is empty or drains
// reset clears the entry count and the response valid; cell contents are not reset
// a stalled rsp holds its beat and req stalls until it is taken
module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  spq_chan_if.sink   req,
  spq_chan_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          full;
  logic          empty;
  logic          accept;
  logic          insert_go;
  logic          pop_go;
  logic [1:0]    status_next;
  cell_cmd_t     cmd;
  rsp_t          rsp_data;
  logic          rsp_valid;

  logic                      ge_chain [DEPTH];
  logic signed [VALUE_W-1:0] cell_value [DEPTH];
  logic [PRIO_W-1:0]         cell_prio [DEPTH];
  logic signed [VALUE_W-1:0] cell_value_next [DEPTH];
  logic [PRIO_W-1:0]         cell_prio_next [DEPTH];

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign insert_go = accept && (req.data.opcode == OP_INSERT) && !full;
  assign pop_go    = accept && (req.data.opcode == OP_POP) && !empty;

  assign cmd.insert = insert_go;
  assign cmd.pop    = pop_go;
  assign cmd.value  = req.data.item_value;
  assign cmd.prio   = req.data.priority_req;

  always_comb begin
    case (req.data.opcode)
      OP_INSERT: status_next = full ? ST_FULL : ST_OK;
      OP_POP:    status_next = empty ? ST_POP_EMPTY : ST_OK;
      default:   status_next = ST_OK;
    endcase
  end

  always_comb begin
    count_next = count;
    if (insert_go) begin
      count_next = count + 1'b1;
    end else if (pop_go) begin
      count_next = count - 1'b1;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic                      left_ge;
    logic signed [VALUE_W-1:0] left_value;
    logic [PRIO_W-1:0]         left_prio;
    logic signed [VALUE_W-1:0] right_value;
    logic [PRIO_W-1:0]         right_prio;

    if (i == 0) begin : g_first
      assign left_ge    = 1'b1;
      assign left_value = '0;
      assign left_prio  = '0;
    end else begin : g_mid
      assign left_ge    = ge_chain[i-1];
      assign left_value = cell_value[i-1];
      assign left_prio  = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_value = '0;
      assign right_prio  = '0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_prio  = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (IDX < count),
      .left_ge     (left_ge),
      .left_value  (left_value),
      .left_prio   (left_prio),
      .right_value (right_value),
      .right_prio  (right_prio),
      .ge          (ge_chain[i]),
      .value       (cell_value[i]),
      .prio        (cell_prio[i]),
      .value_next  (cell_value_next[i]),
      .prio_next   (cell_prio_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data.entry_count <= COUNT_W'(count_next);
      rsp_data.status      <= status_next;
      if (count_next == '0) begin
        rsp_data.head_value    <= '0;
        rsp_data.head_priority <= '0;
        rsp_data.is_empty      <= 1'b1;
      end else begin
        rsp_data.head_value    <= cell_value_next[0];
        rsp_data.head_priority <= cell_prio_next[0];
        rsp_data.is_empty      <= 1'b0;
      end
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    insert_go |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the count");

  a_pop_empty_flag: assert property (@(posedge clk) disable iff (rst)
    (accept && req.data.opcode == OP_POP && empty)
      |=> rsp.valid && rsp.data.status == ST_POP_EMPTY && rsp.data.is_empty)
    else $error("pop on empty not flagged");

  a_empty_head_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.is_empty)
      |-> rsp.data.head_value == '0 && rsp.data.head_priority == '0)
    else $error("empty queue shows a head");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && req.data.opcode == OP_INSERT && full)
      |=> count == $past(count) && rsp.data.status == ST_FULL)
    else $error("insert into full queue not dropped");
`endif

endmodule
